FILE: rtl/ugwq_pkg.sv
// shared types and constants of the uniform grid window query block
// no dependencies
package ugwq_pkg;

  // ids are six bits wide on every port, so the object count is fixed
  localparam int MAX_OBJECTS = 64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_HIDE   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_CELL_W  = 3'd0,
    CFG_CELL_H  = 3'd1,
    CFG_WIN_C   = 3'd2,
    CFG_WIN_R   = 3'd3,
    CFG_REVIVE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIPE,
    S_CLEAR,
    S_I_CELL,
    S_I_WAIT,
    S_I_WRITE,
    S_Q_CELL,
    S_Q_FILL,
    S_Q_SLOT,
    S_Q_DATA,
    S_Q_EMIT,
    S_Q_NONE,
    S_SEEN_CLR,
    S_DONE
  } state_t;

  // one result word
  typedef struct packed {
    logic [5:0] found_id;
    logic       has_object;
    logic       last;
    logic [1:0] status;
  } result_t;

endpackage

FILE: rtl/ugwq_out_buf.sv
// two-entry skid buffer on the result channel
// depends on ugwq_pkg
module ugwq_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ugwq_pkg::result_t  push_data,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output ugwq_pkg::result_t  out_data
);
  import ugwq_pkg::*;

  result_t   buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign has_room  = (cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= push_data;
  end

endmodule

FILE: rtl/ugwq_engine.sv
// sequencer holding the cell memories and object flags
// depends on ugwq_pkg
module ugwq_engine #(
  parameter int GRID_ROWS   = 16,
  parameter int GRID_COLS   = 64,
  parameter int CELL_DEPTH  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic [5:0]         object_id,
  input  logic [15:0]        left_x,
  input  logic [15:0]        top_y,
  input  logic [15:0]        right_x,
  input  logic [15:0]        bottom_y,
  input  logic [15:0]        cam_x,
  input  logic [15:0]        cam_y,
  input  logic [3:0]         wsh,
  input  logic [3:0]         hsh,
  input  logic [6:0]         wcols,
  input  logic [4:0]         wrows,
  input  logic               revive,
  output logic               idle,
  input  logic               room,
  output logic               push,
  output ugwq_pkg::result_t  push_data
);
  import ugwq_pkg::*;

  localparam int NC  = GRID_ROWS * GRID_COLS;
  localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
  localparam int FW  = $clog2(CELL_DEPTH + 1);
  localparam int OW  = $clog2(MAX_OBJECTS);
  localparam int NSL = NC * CELL_DEPTH;
  localparam int AW  = (NSL > 1) ? $clog2(NSL) : 1;

  logic [FW-1:0] fill_mem [NC];
  logic [5:0]    slot_mem [NSL];
  logic [FW-1:0] fill_rd_r;
  logic [5:0]    slot_rd_r;
  logic [MAX_OBJECTS-1:0] vis_r, seen_r;
  logic [CIW-1:0] wipe_r;

  state_t state_r, state_nxt;
  logic [16:0] r0_r, r1_r, c0_r, c1_r, r_r, c_r;
  logic [16:0] r_nxt, c_nxt;
  logic [FW-1:0] s_r, s_nxt, fcur_r, fcur_nxt;
  logic [1:0] st_r, st_nxt;
  logic [5:0] pend_r, pend_nxt;
  logic       hasp_r, hasp_nxt;
  logic [6:0] wc_r, ci_r, ci_nxt;
  logic [4:0] wr_r, ri_r, ri_nxt;
  logic [5:0] cur_id_r, cur_id_nxt;

  logic [CIW-1:0] cell_idx;
  logic [AW-1:0]  slot_addr;
  logic fill_rd_en, fill_wr_en, slot_wr_en, slot_rd_en;
  logic [FW-1:0] fill_wdata;
  logic [FW-1:0] fill_q;
  logic [16:0] qr, qc;
  logic vis_set, vis_clr, seen_set;
  logic [OW-1:0] flag_id;
  logic id_ok;
  logic [6:0] wc_eff;
  logic [4:0] wr_eff;
  logic [16:0] r0_i, r1_i, c0_i, c1_i;
  logic [16:0] q_r0_i, q_c0_i;
  logic        q_out;

  assign id_ok  = ({1'b0, object_id} < 7'(MAX_OBJECTS));
  assign wc_eff = (wcols == 7'd0) ? 7'd1 : ((wcols > 7'd64) ? 7'd64 : wcols);
  assign wr_eff = (wrows == 5'd0) ? 5'd1 : ((wrows > 5'd16) ? 5'd16 : wrows);
  assign r0_i = 17'(top_y >> hsh);
  assign r1_i = 17'(bottom_y >> hsh);
  assign c0_i = 17'(left_x >> wsh);
  assign c1_i = 17'(right_x >> wsh);
  assign q_r0_i = 17'(cam_y >> hsh);
  assign q_c0_i = 17'(cam_x >> wsh);
  // a window reaching past the grid flags every word of the query
  assign q_out  = (q_r0_i + 17'(wr_eff) > 17'(GRID_ROWS)) ||
                  (q_c0_i + 17'(wc_eff) > 17'(GRID_COLS));

  // query cell coordinates
  assign qr = r0_r + 17'(ri_r);
  assign qc = c0_r + 17'(ci_r);

  always_comb begin
    if (state_r == S_WIPE)
      cell_idx = wipe_r;
    else if (state_r == S_I_CELL || state_r == S_I_WAIT || state_r == S_I_WRITE)
      cell_idx = CIW'(r_r) * CIW'(GRID_COLS) + CIW'(c_r);
    else
      cell_idx = CIW'(qr) * CIW'(GRID_COLS) + CIW'(qc);
  end

  assign fill_q = fill_rd_r;

  always_ff @(posedge clk) begin
    if (fill_rd_en) fill_rd_r <= fill_mem[cell_idx];
    if (fill_wr_en) fill_mem[cell_idx] <= fill_wdata;
    if (slot_wr_en) slot_mem[slot_addr] <= cur_id_r;
    if (slot_rd_en) slot_rd_r <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r     <= '0;
      seen_r    <= '0;
      wipe_r    <= '0;
    end else begin
      if (state_r == S_WIPE) wipe_r <= wipe_r + CIW'(1);
      if (vis_set) vis_r[flag_id] <= 1'b1;
      if (vis_clr) vis_r[flag_id] <= 1'b0;
      if (seen_set) seen_r[flag_id] <= 1'b1;
      if (state_r == S_CLEAR) seen_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt; c_r <= c_nxt; s_r <= s_nxt; fcur_r <= fcur_nxt;
    st_r <= st_nxt; pend_r <= pend_nxt; hasp_r <= hasp_nxt;
    ci_r <= ci_nxt; ri_r <= ri_nxt; cur_id_r <= cur_id_nxt;
    if (start) begin
      if (kind == KIND_QUERY) begin
        r0_r <= q_r0_i;
        c0_r <= q_c0_i;
      end else begin
        r0_r <= r0_i;
        c0_r <= c0_i;
      end
      r1_r <= (r1_i >= 17'(GRID_ROWS)) ? 17'(GRID_ROWS - 1) : r1_i;
      c1_r <= (c1_i >= 17'(GRID_COLS)) ? 17'(GRID_COLS - 1) : c1_i;
      wc_r <= wc_eff;
      wr_r <= wr_eff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r; c_nxt = c_r; s_nxt = s_r; fcur_nxt = fcur_r;
    st_nxt = st_r; pend_nxt = pend_r; hasp_nxt = hasp_r;
    ci_nxt = ci_r; ri_nxt = ri_r; cur_id_nxt = cur_id_r;
    fill_rd_en = 1'b0; fill_wr_en = 1'b0; fill_wdata = fill_q + FW'(1);
    slot_wr_en = 1'b0; slot_rd_en = 1'b0;
    slot_addr  = AW'(cell_idx) * AW'(CELL_DEPTH) + AW'(s_r);
    vis_set = 1'b0; vis_clr = 1'b0; seen_set = 1'b0;
    flag_id = cur_id_r[OW-1:0];
    push = 1'b0;
    push_data = '{found_id: 6'd0, has_object: 1'b0, last: 1'b1, status: st_r};
    idle = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_id_nxt = object_id;
          st_nxt = ST_OK;
          unique case (kind)
            KIND_INSERT: begin
              if (id_ok) begin
                vis_set = 1'b1;
                flag_id = object_id[OW-1:0];
                if (r0_i > r1_i || c0_i > c1_i) begin
                  state_nxt = S_DONE;
                end else begin
                  if (r1_i >= 17'(GRID_ROWS) || c1_i >= 17'(GRID_COLS)) st_nxt = ST_OUTSIDE;
                  r_nxt = r0_i; c_nxt = c0_i;
                  state_nxt = S_I_CELL;
                end
              end else begin
                state_nxt = S_DONE;
              end
            end
            KIND_HIDE: begin
              if (id_ok) begin
                vis_clr = 1'b1;
                flag_id = object_id[OW-1:0];
              end
              state_nxt = S_DONE;
            end
            KIND_QUERY: begin
              ri_nxt = 5'd0; ci_nxt = 7'd0; hasp_nxt = 1'b0;
              if (q_out) st_nxt = ST_OUTSIDE;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // zero one cell fill per cycle after reset
      S_WIPE: begin
        fill_wr_en = 1'b1;
        fill_wdata = '0;
        if (wipe_r == CIW'(NC - 1)) state_nxt = S_IDLE;
      end
      S_CLEAR: state_nxt = S_Q_CELL;
      S_I_CELL: begin
        if (r_r > r1_r || r_r >= 17'(GRID_ROWS)) begin
          state_nxt = S_DONE;
        end else if (c_r > c1_r || c_r >= 17'(GRID_COLS)) begin
          r_nxt = r_r + 17'd1; c_nxt = c0_r;
        end else begin
          fill_rd_en = 1'b1;
          state_nxt = S_I_WAIT;
        end
      end
      S_I_WAIT: begin
        s_nxt = fill_q;
        fcur_nxt = fill_q;
        state_nxt = S_I_WRITE;
      end
      S_I_WRITE: begin
        if (fcur_r >= FW'(CELL_DEPTH)) begin
          if (st_r == ST_OK) st_nxt = ST_FULL;
        end else begin
          slot_wr_en = 1'b1;
          fill_wr_en = 1'b1;
          fill_wdata = fcur_r + FW'(1);
        end
        c_nxt = c_r + 17'd1;
        state_nxt = S_I_CELL;
      end
      S_Q_CELL: begin
        if (ri_r >= wr_r) begin
          state_nxt = hasp_r ? S_Q_EMIT : S_Q_NONE;
        end else if (ci_r >= wc_r) begin
          ri_nxt = ri_r + 5'd1; ci_nxt = 7'd0;
        end else if (qr >= 17'(GRID_ROWS) || qc >= 17'(GRID_COLS)) begin
          st_nxt = ST_OUTSIDE;
          ci_nxt = ci_r + 7'd1;
        end else begin
          fill_rd_en = 1'b1;
          state_nxt = S_Q_FILL;
        end
      end
      S_Q_FILL: begin
        fcur_nxt = fill_q;
        s_nxt = '0;
        state_nxt = S_Q_SLOT;
      end
      S_Q_SLOT: begin
        if (s_r >= fcur_r || s_r >= FW'(CELL_DEPTH)) begin
          ci_nxt = ci_r + 7'd1;
          state_nxt = S_Q_CELL;
        end else begin
          slot_rd_en = 1'b1;
          state_nxt = S_Q_DATA;
        end
      end
      S_Q_DATA: begin
        s_nxt = s_r + FW'(1);
        state_nxt = S_Q_SLOT;
        if ({1'b0, slot_rd_r} < 7'(MAX_OBJECTS)) begin
          flag_id = slot_rd_r[OW-1:0];
          if (!vis_r[flag_id] && revive) vis_set = 1'b1;
          if ((vis_r[flag_id] || revive) && !seen_r[flag_id]) begin
            seen_set = 1'b1;
            // hold one found id so last can be marked on the final one
            if (hasp_r) begin
              if (room) begin
                push = 1'b1;
                push_data = '{found_id: pend_r, has_object: 1'b1, last: 1'b0,
                              status: st_r};
                pend_nxt = slot_rd_r;
              end else begin
                seen_set = 1'b0; vis_set = 1'b0;
                s_nxt = s_r;
                state_nxt = S_Q_DATA;
              end
            end else begin
              pend_nxt = slot_rd_r; hasp_nxt = 1'b1;
            end
          end
        end
      end
      S_Q_EMIT: begin
        if (room) begin
          push = 1'b1;
          push_data = '{found_id: pend_r, has_object: 1'b1, last: 1'b1, status: st_r};
          state_nxt = S_IDLE;
        end
      end
      S_Q_NONE, S_DONE: begin
        if (room) begin
          push = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEEN_CLR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/uniform_grid_window_query.sv
// uniform grid spatial index: insert, hide and window query over a cell memory
// depends on ugwq_pkg, ugwq_engine, ugwq_out_buf
//
// channels: in_* words carry insert, query or hide items (valid/ready);
// out_* words carry results (valid/ready); cfg_* writes the five registers.
// one item is processed at a time; in_ready is high only while idle.
// an insert reads and then updates the fill of each covered cell in turn,
// row by row; a query walks the window cells row by row, reading the fill
// of each in-grid cell and then each of its stored slots. the fill/slot
// memories take one access per cycle. found objects enter a two-entry
// result buffer; when out_ready is low and the buffer is full the walk
// stalls. after reset a wipe pass zeroes the cell fills one cell per
// cycle, GRID_ROWS*GRID_COLS cells (1024 by default), with in_ready low;
// flags and registers take their reset values at once.
// the seen map is cleared in the S_CLEAR state at the start of each query.
// configure only while idle.
module uniform_grid_window_query #(
  parameter int GRID_ROWS   = 16,
  parameter int GRID_COLS   = 64,
  parameter int CELL_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_object_id,
  input  logic [15:0] in_left_x,
  input  logic [15:0] in_top_y,
  input  logic [15:0] in_right_x,
  input  logic [15:0] in_bottom_y,
  input  logic [15:0] in_cam_x,
  input  logic [15:0] in_cam_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_found_id,
  output logic        out_has_object,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import ugwq_pkg::*;

  logic [3:0] wsh_r, hsh_r;
  logic [6:0] wc_r;
  logic [4:0] wr_r;
  logic       rev_r;
  logic       idle, room, push, start;
  result_t    push_data, out_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign start     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsh_r <= 4'd5; hsh_r <= 4'd5; wc_r <= 7'd17; wr_r <= 5'd9; rev_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CELL_W: wsh_r <= cfg_data[3:0];
        CFG_CELL_H: hsh_r <= cfg_data[3:0];
        CFG_WIN_C:  wc_r  <= cfg_data;
        CFG_WIN_R:  wr_r  <= cfg_data[4:0];
        CFG_REVIVE: rev_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ugwq_engine #(
    .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .CELL_DEPTH(CELL_DEPTH)
  ) u_engine (
    .clk, .rst_n, .start,
    .kind(in_kind), .object_id(in_object_id),
    .left_x(in_left_x), .top_y(in_top_y), .right_x(in_right_x), .bottom_y(in_bottom_y),
    .cam_x(in_cam_x), .cam_y(in_cam_y),
    .wsh(wsh_r), .hsh(hsh_r), .wcols(wc_r), .wrows(wr_r), .revive(rev_r),
    .idle, .room, .push, .push_data
  );

  ugwq_out_buf u_out (
    .clk, .rst_n, .push, .push_data, .has_room(room),
    .out_valid, .out_ready, .out_data
  );

  assign out_found_id   = out_data.found_id;
  assign out_has_object = out_data.has_object;
  assign out_last       = out_data.last;
  assign out_status     = out_data.status;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> room)
    else $error("result pushed into occupied buffer");
  a_no_obj_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_object |-> out_found_id == 6'd0 && out_last)
    else $error("empty result malformed");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !idle)
    else $error("engine stayed idle after accept");

endmodule

FILE: dv/ugwq_checker.sv
// result checker for uniform_grid_window_query: watches the cfg, in and out channels,
// keeps its own copy of the grid and flags, and compares every result word in order
// depends on ugwq_pkg
`timescale 1ns / 1ps

module ugwq_checker
  import ugwq_pkg::*;
#(
  parameter int GRID_ROWS  = 16,
  parameter int GRID_COLS  = 64,
  parameter int CELL_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_object_id,
  input  logic [15:0] in_left_x,
  input  logic [15:0] in_top_y,
  input  logic [15:0] in_right_x,
  input  logic [15:0] in_bottom_y,
  input  logic [15:0] in_cam_x,
  input  logic [15:0] in_cam_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_found_id,
  input  logic        out_has_object,
  input  logic        out_last,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NCELLS = GRID_ROWS * GRID_COLS;

  logic [5:0] grid_ids  [NCELLS * CELL_DEPTH];
  logic [3:0] grid_fill [NCELLS];
  bit         shown     [64];
  logic [3:0] w_shift, h_shift;
  logic [6:0] win_cols;
  logic [4:0] win_rows;
  logic       revive;
  result_t    expected_words[$];

  function automatic void add_word(logic [5:0] id, logic has, logic lst, status_t st);
    result_t w;
    w.found_id   = id;
    w.has_object = has;
    w.last       = lst;
    w.status     = st;
    expected_words = {expected_words, w};
  endfunction

  function automatic void place_object(logic [5:0] id, logic [15:0] lx, logic [15:0] ty,
                                       logic [15:0] rx, logic [15:0] by);
    int r0, r1, c0, c1, cell_ix;
    bit outside, full;
    status_t st;
    outside = 1'b0;
    full = 1'b0;
    shown[id] = 1'b1;
    r0 = int'(ty >> h_shift);
    r1 = int'(by >> h_shift);
    c0 = int'(lx >> w_shift);
    c1 = int'(rx >> w_shift);
    if (r0 <= r1 && c0 <= c1) begin
      if (r1 >= GRID_ROWS || c1 >= GRID_COLS) outside = 1'b1;
      if (r1 >= GRID_ROWS) r1 = GRID_ROWS - 1;
      if (c1 >= GRID_COLS) c1 = GRID_COLS - 1;
      for (int r = r0; r <= r1 && r < GRID_ROWS; r++) begin
        for (int c = c0; c <= c1 && c < GRID_COLS; c++) begin
          cell_ix = r * GRID_COLS + c;
          if (grid_fill[cell_ix] >= CELL_DEPTH) begin
            full = 1'b1;
          end else begin
            grid_ids[cell_ix * CELL_DEPTH + int'(grid_fill[cell_ix])] = id;
            grid_fill[cell_ix] = grid_fill[cell_ix] + 4'd1;
          end
        end
      end
    end
    st = outside ? ST_OUTSIDE : (full ? ST_FULL : ST_OK);
    add_word(6'd0, 1'b0, 1'b1, st);
  endfunction

  function automatic void scan_window(logic [15:0] cx, logic [15:0] cy);
    int row0, col0, nr, nc, gr, gc, cell_ix;
    logic [5:0] id;
    logic [5:0] hits[$];
    bit met[64];
    status_t st;
    st = ST_OK;
    row0 = int'(cy >> h_shift);
    col0 = int'(cx >> w_shift);
    nr = int'(win_rows);
    nc = int'(win_cols);
    if (nr < 1) nr = 1;
    if (nr > 16) nr = 16;
    if (nc < 1) nc = 1;
    if (nc > 64) nc = 64;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        gr = row0 + r;
        gc = col0 + c;
        if (gr >= GRID_ROWS || gc >= GRID_COLS) begin
          st = ST_OUTSIDE;
        end else begin
          cell_ix = gr * GRID_COLS + gc;
          for (int s = 0; s < int'(grid_fill[cell_ix]) && s < CELL_DEPTH; s++) begin
            id = grid_ids[cell_ix * CELL_DEPTH + s];
            if (!shown[id] && revive) shown[id] = 1'b1;
            if (shown[id] && !met[id]) begin
              met[id] = 1'b1;
              hits = {hits, id};
            end
          end
        end
      end
    end
    if (hits.size() == 0) add_word(6'd0, 1'b0, 1'b1, st);
    foreach (hits[k]) add_word(hits[k], 1'b1, k == hits.size() - 1, st);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (grid_fill[i]) grid_fill[i] = '0;
      foreach (shown[i]) shown[i] = 1'b0;
      w_shift  = 4'd5;
      h_shift  = 4'd5;
      win_cols = 7'd17;
      win_rows = 5'd9;
      revive   = 1'b0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CELL_W: w_shift  = cfg_data[3:0];
          CFG_CELL_H: h_shift  = cfg_data[3:0];
          CFG_WIN_C:  win_cols = cfg_data;
          CFG_WIN_R:  win_rows = cfg_data[4:0];
          CFG_REVIVE: revive   = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word id=%0d has=%0b last=%0b status=%0d",
                     $realtime, out_found_id, out_has_object, out_last, out_status);
        end else begin
          want = expected_words.pop_front();
          if (want.found_id !== out_found_id || want.has_object !== out_has_object ||
              want.last !== out_last || want.status !== out_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp id=%0d has=%0b last=%0b status=%0d,",
                        " got id=%0d has=%0b last=%0b status=%0d"},
                       $realtime, want.found_id, want.has_object, want.last, want.status,
                       out_found_id, out_has_object, out_last, out_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (kind_t'(in_kind))
          KIND_INSERT: place_object(in_object_id, in_left_x, in_top_y, in_right_x, in_bottom_y);
          KIND_QUERY:  scan_window(in_cam_x, in_cam_y);
          KIND_HIDE: begin
            shown[in_object_id] = 1'b0;
            add_word(6'd0, 1'b0, 1'b1, ST_OK);
          end
          default: add_word(6'd0, 1'b0, 1'b1, ST_OK);
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: dv/tb.sv
// top of the uniform_grid_window_query testbench: clock, reset, stimulus and verdict
// depends on ugwq_pkg, ugwq_checker and the rtl
`timescale 1ns / 1ps

module tb;
  import ugwq_pkg::*;

  localparam int LIMIT = 10000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [5:0]  in_object_id = '0;
  logic [15:0] in_left_x = '0, in_top_y = '0, in_right_x = '0, in_bottom_y = '0;
  logic [15:0] in_cam_x = '0, in_cam_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_found_id;
  logic        out_has_object, out_last;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  int          fail_count, pending;
  int          cycles = 0;
  int          stall = 0;
  bit          calm = 0;
  int          cur_ws = 5, cur_hs = 5;

  uniform_grid_window_query dut (.*);
  ugwq_checker chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20)
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(kind_t k, logic [5:0] id, logic [15:0] lx, logic [15:0] ty,
                           logic [15:0] rx, logic [15:0] by, logic [15:0] cx,
                           logic [15:0] cy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind      <= k;
    in_object_id <= id;
    in_left_x    <= lx;
    in_top_y     <= ty;
    in_right_x   <= rx;
    in_bottom_y  <= by;
    in_cam_x     <= cx;
    in_cam_y     <= cy;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off input until every result has drained, then let the walk finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(int ws, int hs, int wc, int wr, int rev);
    cfg_idx_t idx[5];
    int val[5];
    drain();
    idx = '{CFG_CELL_W, CFG_CELL_H, CFG_WIN_C, CFG_WIN_R, CFG_REVIVE};
    val = '{ws, hs, wc, wr, rev};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i][6:0];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_ws = ws;
    cur_hs = hs;
  endtask

  function automatic logic [15:0] pick_coord(int shift, int ncells);
    longint span;
    span = longint'(ncells) << shift;
    if ($urandom_range(0, 9) == 0 || span > 65536) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, int'(span) - 1));
  endfunction

  task automatic random_word();
    int r, e0, e1;
    logic [15:0] lx, ty, rx, by, t;
    r = $urandom_range(0, 99);
    lx = pick_coord(cur_ws, 64);
    ty = pick_coord(cur_hs, 16);
    e0 = int'(lx) + int'($urandom_range(0, 2 << cur_ws));
    e1 = int'(ty) + int'($urandom_range(0, 2 << cur_hs));
    rx = (e0 > 65535) ? 16'hffff : e0[15:0];
    by = (e1 > 65535) ? 16'hffff : e1[15:0];
    if ($urandom_range(0, 19) == 0) begin
      t = lx; lx = rx; rx = t;
    end
    if (r < 45)
      send_word(KIND_INSERT, 6'($urandom_range(0, 63)), lx, ty, rx, by,
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    else if (r < 80)
      send_word(KIND_QUERY, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), lx, ty);
    else if (r < 95)
      send_word(KIND_HIDE, 6'($urandom_range(0, 63)), lx, ty, rx, by, lx, ty);
    else
      send_word(KIND_NOP, 6'($urandom_range(0, 63)), lx, ty, rx, by, rx, by);
  endtask

  initial begin
    int ws[4], hs[4], wc[4], wr[4], rv[4];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset register values
    send_word(KIND_INSERT, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(KIND_INSERT, 6'd63, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'd0);
    send_word(KIND_INSERT, 6'd5, 16'd100, 16'd0, 16'd10, 16'd0, 16'd0, 16'd0);
    send_word(KIND_INSERT, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 1; i <= 7; i++)
      send_word(KIND_INSERT, i[5:0], 16'd3, 16'd3, 16'd3, 16'd3, 16'd0, 16'd0);
    send_word(KIND_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(KIND_HIDE, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(KIND_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(KIND_NOP, 6'd63, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(KIND_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'hffff);
    send_word(KIND_INSERT, 6'd10, 16'd30, 16'd30, 16'd40, 16'd40, 16'd0, 16'd0);
    send_word(KIND_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd20, 16'd20);
    send_word(KIND_QUERY, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2000, 16'd500);

    // phases: zero windows with smallest cells, oversize windows with largest cells,
    // a full window, then a small one
    ws = '{0, 15, 10, 6};
    hs = '{0, 15, 12, 5};
    wc = '{0, 127, 64, 8};
    wr = '{0, 31, 16, 4};
    rv = '{1, 0, 1, 0};
    for (int p = 0; p < 4; p++) begin
      set_regs(ws[p], hs[p], wc[p], wr[p], rv[p]);
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 25; n++) begin
        if (n == 12) drain();
        random_word();
      end
    end
    calm = 0;

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: uniform_grid_window_query.f
rtl/ugwq_pkg.sv
rtl/ugwq_out_buf.sv
rtl/ugwq_engine.sv
rtl/uniform_grid_window_query.sv
dv/ugwq_checker.sv
dv/tb.sv
